@@ src/hmc_pkg.sv @@
// hmc_pkg: sizes, command codes and neighbor tap types for the huffman merge cost block
// used by hmc_cell, hmc_chain and huffman_merge_cost; depends on nothing
package hmc_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int LENGTH_W  = 32;
   localparam int ENTRY_W   = 48;
   localparam int COST_W    = 64;
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_MERGE  = 2'd2
   } hmc_op_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      hmc_op_type          op;
      logic [ENTRY_W-1:0]  key;
   } hmc_cmd_type;

   // what a cell shows its neighbors: its value and whether it is valid and <= key
   typedef struct packed {
      logic                le;
      logic [ENTRY_W-1:0]  value;
   } hmc_tap_type;

endpackage

@@ src/hmc_cell.sv @@
// hmc_cell: one slot of the sorted chain, holding one entry
// depends on hmc_pkg; instantiated by hmc_chain
module hmc_cell
   import hmc_pkg::*;
(
   input  logic        clock,
   input  hmc_cmd_type cmd,
   input  logic        valid,
   input  hmc_tap_type left_tap,
   input  hmc_tap_type right1_tap,
   input  hmc_tap_type right2_tap,
   output hmc_tap_type tap
);

   logic [ENTRY_W-1:0] value_ff;
   logic [ENTRY_W-1:0] value_in;
   logic               le;

   assign le  = valid && (value_ff <= cmd.key);
   assign tap = '{le: le, value: value_ff};

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            // entries above the key shift up one slot, key lands in the gap
            if (le) begin
               value_in = value_ff;
            end else if (left_tap.le) begin
               value_in = cmd.key;
            end else begin
               value_in = left_tap.value;
            end
         end
         OP_MERGE: begin
            // drop the two head entries and insert their sum in one step
            if (right2_tap.le) begin
               value_in = right2_tap.value;
            end else if (right1_tap.le) begin
               value_in = cmd.key;
            end else begin
               value_in = right1_tap.value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ src/hmc_chain.sv @@
// hmc_chain: row of hmc_cell slots kept in ascending order, smallest at slot 0
// depends on hmc_pkg and hmc_cell; instantiated by huffman_merge_cost
module hmc_chain
   import hmc_pkg::*;
(
   input  logic               clock,
   input  hmc_cmd_type        cmd,
   input  logic [COUNT_W-1:0] count,
   output logic [ENTRY_W-1:0] head_value0,
   output logic [ENTRY_W-1:0] head_value1
);

   localparam hmc_tap_type LEFT_EDGE  = '{le: 1'b1, value: '0};
   localparam hmc_tap_type RIGHT_EDGE = '{le: 1'b0, value: '0};

   hmc_tap_type taps        [MAX_ITEMS];
   hmc_tap_type left_taps   [MAX_ITEMS];
   hmc_tap_type right1_taps [MAX_ITEMS];
   hmc_tap_type right2_taps [MAX_ITEMS];
   logic        valids      [MAX_ITEMS];

   genvar g;
   generate
      for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
         assign valids[g] = (COUNT_W'(g) < count);

         if (g == 0) begin : g_left_edge
            assign left_taps[g] = LEFT_EDGE;
         end else begin : g_left
            assign left_taps[g] = taps[g-1];
         end

         if (g + 1 < MAX_ITEMS) begin : g_right1
            assign right1_taps[g] = taps[g+1];
         end else begin : g_right1_edge
            assign right1_taps[g] = RIGHT_EDGE;
         end

         if (g + 2 < MAX_ITEMS) begin : g_right2
            assign right2_taps[g] = taps[g+2];
         end else begin : g_right2_edge
            assign right2_taps[g] = RIGHT_EDGE;
         end

         hmc_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .valid      (valids[g]),
            .left_tap   (left_taps[g]),
            .right1_tap (right1_taps[g]),
            .right2_tap (right2_taps[g]),
            .tap        (taps[g])
         );
      end
   endgenerate

   assign head_value0 = taps[0].value;
   assign head_value1 = taps[1].value;

endmodule

@@ src/huffman_merge_cost.sv @@
// huffman_merge_cost: top level, load and merge control plus the result register
// depends on hmc_pkg and hmc_chain
//
// Usage:
//   req channel: one length per word in req_tdata, req_tlast marks the final
//   length of a set. Each accepted word is inserted into a sorted chain of
//   MAX_ITEMS cells in the same cycle.
//   Words that arrive while the chain is full are dropped and the result is
//   flagged in rsp_tuser.
//   After the last word, the merge phase runs until one entry is held:
//   each cycle the two head cells are summed, the sum is added to the cost
//   and reinserted across the whole chain. The result register is then
//   loaded once the rsp slot is free.
//   req_tready is low during the merge phase. A held result does not block
//   loading of the next set; it only delays the end of the next merge phase.
//   rsp channel: total cost in rsp_tdata, overflow flag in rsp_tuser. A stalled
//   receiver keeps the word held until rsp_tready.
//   reset clears the cell count, flags and result valid; the cells themselves
//   need no clearing since only slots below the count are ever compared.
module huffman_merge_cost
   import hmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] length
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] total_cost
   output logic [0:0]  rsp_tuser    // [0] overflowed
);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   hmc_cmd_type        cmd;
   logic [ENTRY_W-1:0] head_value0;
   logic [ENTRY_W-1:0] head_value1;
   logic [ENTRY_W-1:0] pair_sum;
   logic               req_fire;
   logic               chain_full;
   logic               slot_free;
   logic               emit;

   hmc_chain u_chain (
      .clock       (clock),
      .cmd         (cmd),
      .count       (count_ff),
      .head_value0 (head_value0),
      .head_value1 (head_value1)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign chain_full = (count_ff == COUNT_W'(MAX_ITEMS));
   assign pair_sum   = head_value0 + head_value1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit       = (state_ff == ST_MERGE) && (count_ff <= COUNT_W'(1)) && slot_free;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      cost_in      = cost_ff;
      cmd          = '{op: OP_HOLD, key: '0};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cost_in  = rsp_cost_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (chain_full) begin
                  overflow_in = 1'b1;
               end else begin
                  cmd      = '{op: OP_INSERT, key: ENTRY_W'(req_tdata)};
                  count_in = count_ff + COUNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            if (count_ff > COUNT_W'(1)) begin
               cmd      = '{op: OP_MERGE, key: pair_sum};
               count_in = count_ff - COUNT_W'(1);
               cost_in  = cost_ff + COST_W'(pair_sum);
            end else if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = cost_ff;
               rsp_ovf_in   = overflow_ff;
               count_in     = '0;
               overflow_in  = 1'b0;
               cost_in      = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff <= rsp_cost_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_cost_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ITEMS))
      else $error("cell count above capacity");

   a_merge_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) && (count_ff > COUNT_W'(1)) |=>
         (count_ff == $past(count_ff) - COUNT_W'(1)) && (state_ff == ST_MERGE))
      else $error("merge step did not retire exactly one entry");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && (count_ff == '0) && !overflow_ff && (cost_ff == '0)
               && (state_ff == ST_LOAD))
      else $error("result load did not clear the set");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      emit |-> (count_ff <= COUNT_W'(1)))
      else $error("result loaded before merging finished");
`endif

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for huffman_merge_cost, predicts the merge cost of each set of lengths
// depends on hmc_pkg and the huffman_merge_cost rtl
`timescale 1ns / 100ps

module tb
   import hmc_pkg::*;
();

   localparam int LONG_HOLD  = 600;
   localparam int TAIL_WAIT  = 40;

   typedef struct {
      logic [LENGTH_W-1:0] length;
      logic                last;
   } len_word_type;

   typedef struct {
      logic [COST_W-1:0] cost;
      logic              overflowed;
   } cost_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] length
   logic        req_tlast = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [63:0] total_cost
   logic [0:0]  rsp_tuser;        // [0] overflowed

   len_word_type        pending_words[$];
   cost_result_type     expected_costs[$];
   logic [ENTRY_W-1:0]  held_lengths[$];
   logic                set_overflow = 1'b0;
   int unsigned         sender_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   logic                rsp_holding = 1'b0;
   int unsigned         error_count = 0;
   event                hold_start;

   huffman_merge_cost i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // take the two smallest, add, put the sum back, until one entry is left
   function automatic logic [COST_W-1:0] huffman_cost(input logic [ENTRY_W-1:0] pool[$]);
      logic [COST_W-1:0]  cost;
      logic [ENTRY_W-1:0] a;
      logic [ENTRY_W-1:0] b;
      logic [ENTRY_W-1:0] s;
      int                 i;
      cost = '0;
      pool.sort();
      while (pool.size() > 1) begin
         a = pool.pop_front();
         b = pool.pop_front();
         s = a + b;
         cost += COST_W'(s);
         i = 0;
         while (i < pool.size() && pool[i] <= s)
            i++;
         pool.insert(i, s);
      end
      return cost;
   endfunction

   function automatic logic [LENGTH_W-1:0] rand_length();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return $urandom_range(15);
         3: return 32'd1 << $urandom_range(31);
         4: return ~(32'd1 << $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   // driver: next word goes out once the current one is taken
   always @(posedge clock) begin : req_driver
      len_word_type next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_word.length;
            req_tlast  <= next_word.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_holding && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long receiver hold-off, counted here so the stimulus side keeps feeding words
   always begin
      @(hold_start);
      rsp_holding <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_holding <= 1'b0;
   end

   // monitor: check results first, then fold in the word taken at this edge
   always @(posedge clock) begin : monitor
      cost_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_costs.size() == 0) begin
               $display("%0t: unexpected word total_cost %h overflowed %b",
                        $time, rsp_tdata, rsp_tuser[0]);
               error_count++;
            end else begin
               want = expected_costs.pop_front();
               if (rsp_tdata !== want.cost) begin
                  $display("%0t: total_cost expected %h actual %h",
                           $time, want.cost, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser[0] !== want.overflowed) begin
                  $display("%0t: overflowed expected %b actual %b",
                           $time, want.overflowed, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (held_lengths.size() < MAX_ITEMS)
               held_lengths.push_back(ENTRY_W'(req_tdata));
            else
               set_overflow = 1'b1;
            if (req_tlast) begin
               want.cost = huffman_cost(held_lengths);
               want.overflowed = set_overflow;
               expected_costs.push_back(want);
               held_lengths.delete();
               set_overflow = 1'b0;
            end
         end
      end
   end

   task automatic push_word(input logic [LENGTH_W-1:0] length, input logic last);
      len_word_type w;
      w.length = length;
      w.last = last;
      pending_words.push_back(w);
   endtask

   task automatic push_random_set(input int n);
      for (int k = 0; k < n; k++)
         push_word(rand_length(), k == n - 1);
   endtask

   // waits until every queued word is sent and every expected cost has come back
   task automatic wait_drain();
      while (pending_words.size() != 0 || req_tvalid || expected_costs.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                            input int n_words);
      int sent;
      int n;
      sent = 0;
      @(negedge clock);
      sender_idle_pct = s_pct;
      rsp_stall_pct = r_pct;
      while (sent < n_words) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
         push_random_set(n);
         sent += n;
      end
      wait_drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single item sets, then small sets of extreme values
      push_word('0, 1'b1);
      push_word('1, 1'b1);
      push_word('1, 1'b0);
      push_word('1, 1'b1);
      push_word('0, 1'b0);
      push_word('0, 1'b0);
      push_word('0, 1'b1);
      push_word(32'hAAAA_AAAA, 1'b0);
      push_word(32'h5555_5555, 1'b0);
      push_word(32'd1, 1'b0);
      push_word(32'h8000_0000, 1'b1);
      // equal entries, then a set of 1 to 6
      for (int k = 0; k < 4; k++)
         push_word(32'd5, k == 3);
      for (int k = 1; k <= 6; k++)
         push_word(k, k == 6);
      wait_drain();

      run_phase(0, 0, 80);
      run_phase(58, 0, 80);
      run_phase(0, 58, 80);
      run_phase(36, 36, 80);

      // receiver holds off while sets keep coming, so the input backs up
      @(negedge clock);
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_start;
      for (int k = 0; k < 10; k++)
         push_random_set($urandom_range(2, 8));
      wait_drain();

      repeat (TAIL_WAIT) @(negedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
src/hmc_pkg.sv
src/hmc_cell.sv
src/hmc_chain.sv
src/huffman_merge_cost.sv
test/tb.sv
